>>> rtl/mqdv_pkg.sv
// ----------------------------------------------------------------------------
// mqdv_pkg - shared types and constants
// Item structs, action codes and the quadrature step table.
// ----------------------------------------------------------------------------
package mqdv_pkg;

	typedef enum logic [2:0] {
		ACT_SAMPLE  = 3'd0,
		ACT_TICK    = 3'd1,
		ACT_RESET   = 3'd2,
		ACT_READ    = 3'd3,
		ACT_PRELOAD = 3'd4
	} action_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  encoder_id;
		logic [1:0]  phase_state;
		logic [31:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] speed;
	} out_item_t;

	// queued command between front and back
	typedef struct packed {
		action_t     action;
		logic        id_ok;
		logic [7:0]  encoder_id;
		logic [1:0]  phase_state;
		logic [31:0] time_us;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_SCAN, BK_MUL, BK_DIV, BK_WRITE
	} bk_state_t;

	localparam logic [31:0] WINDOW_RESET      = 32'd10000;
	localparam logic [19:0] MICROS_PER_SECOND = 20'd1000000;
	localparam int unsigned QUEUE_DEPTH       = 2;

	// step from previous phase (row) and new phase (column)
	function automatic logic [1:0] step_lut(input logic [1:0] prev, input logic [1:0] cur);
		logic [1:0] r;
		r = 2'b00;
		case ({prev, cur})
			4'b0001: r = 2'b11;
			4'b0010: r = 2'b01;
			4'b0100: r = 2'b01;
			4'b0111: r = 2'b11;
			4'b1000: r = 2'b11;
			4'b1011: r = 2'b01;
			4'b1101: r = 2'b01;
			4'b1110: r = 2'b11;
			default: r = 2'b00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/multi_quadrature_decoder_velocity_unit.sv
// ----------------------------------------------------------------------------
// multi_quadrature_decoder_velocity_unit - quadrature position and velocity
// Tracks count and speed for a bank of quadrature encoders.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// in        start / busy       in_item (action, encoder_id, phase_state, time_us)
// out       done strobe        result (position, speed)
// cfg       window_we          window_wdata (window_us)
//
// Sample, reset, preload and read are applied when the back end pops them; a read
// result strobes in the cycle after the item leaves the two-entry queue.
// A tick sweeps the encoders in turn: an encoder not due is scanned and skipped;
// one that is due goes through the product stage, the shared bit-serial divider and a write.
// busy rises only when the queue is full. Reset is asynchronous; the results
// cannot be held off.
// ----------------------------------------------------------------------------
module multi_quadrature_decoder_velocity_unit #(
	parameter int unsigned ENCODER_COUNT = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mqdv_pkg::in_item_t  in_item,
	output logic                done,
	output mqdv_pkg::out_item_t result,
	input  logic                window_we,
	input  logic [31:0]         window_wdata
);
	mqdv_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_pop;

	mqdv_front #(.ENCODER_COUNT(ENCODER_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);

	mqdv_back #(.ENCODER_COUNT(ENCODER_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(window_we), .cfg_wdata(window_wdata),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.done(done), .result(result)
	);

endmodule

>>> rtl/mqdv_front.sv
// ----------------------------------------------------------------------------
// mqdv_front - command intake
// Classifies each item, checks the encoder id and queues it for the back end.
// ----------------------------------------------------------------------------
module mqdv_front #(
	parameter int unsigned ENCODER_COUNT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mqdv_pkg::in_item_t in_item,
	output logic              busy,
	output mqdv_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  logic              cmd_pop
);
	localparam int unsigned QD = mqdv_pkg::QUEUE_DEPTH;

	mqdv_pkg::cmd_t queue_q [QD];
	logic [1:0]     count_q;
	logic           wr_ptr_q, rd_ptr_q;
	logic           push;
	mqdv_pkg::cmd_t new_cmd;

	// classify the item
	always_comb begin
		new_cmd.action      = mqdv_pkg::action_t'(in_item.action);
		new_cmd.id_ok       = {24'd0, in_item.encoder_id} < ENCODER_COUNT;
		new_cmd.encoder_id  = in_item.encoder_id;
		new_cmd.phase_state = in_item.phase_state;
		new_cmd.time_us     = in_item.time_us;
	end

	assign busy      = (count_q == 2'(QD));
	assign push      = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= new_cmd;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QD)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> count_q == $past(count_q) + 2'd1) else $error("count slip");

endmodule

>>> rtl/mqdv_divider.sv
// ----------------------------------------------------------------------------
// mqdv_divider - unsigned restoring divider
// 52-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mqdv_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [51:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [51:0] quotient
);
	logic [51:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted  = {rem_q[31:0], quo_q[51]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;

	// one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 6'd0;
			done  <= 1'b0;
		end else begin
			done <= run_q && !go && (cnt_q == 6'd51);
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd51) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= 33'd0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[50:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[50:0], 1'b0};
			end
		end
	end

endmodule

>>> rtl/mqdv_back.sv
// ----------------------------------------------------------------------------
// mqdv_back - per-encoder state and command execution
// Applies samples, resets, preloads and reads; ticks sweep the bank and
// compute velocity through the shared multiply and divider.
// ----------------------------------------------------------------------------
module mqdv_back #(
	parameter int unsigned ENCODER_COUNT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  mqdv_pkg::cmd_t    cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	output logic              done,
	output mqdv_pkg::out_item_t result
);
	localparam int unsigned IW = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;

	logic [31:0] window_q;
	logic [31:0] pos_q  [ENCODER_COUNT];
	logic [1:0]  prev_q [ENCODER_COUNT];
	logic [31:0] vel_q  [ENCODER_COUNT];
	logic [31:0] cw_q   [ENCODER_COUNT];
	logic [31:0] tw_q   [ENCODER_COUNT];

	mqdv_pkg::bk_state_t state_q, state_d;
	logic [IW-1:0] k_q;
	logic [31:0]   now_q, elapsed_q;
	logic [31:0]   dc_mag_s1;
	logic          neg_s1;
	logic [51:0]   prod;
	logic          div_go, div_done;
	logic [51:0]   quo;
	logic [IW-1:0] id;
	logic [1:0]    stp;
	logic [31:0]   win, elapsed_k, dc_k, sat_v;

	assign id        = cmd.encoder_id[IW-1:0];
	assign win       = (window_q == 32'd0) ? 32'd1 : window_q;
	assign elapsed_k = now_q - tw_q[k_q];
	assign dc_k      = pos_q[k_q] - cw_q[k_q];
	assign div_go    = (state_q == mqdv_pkg::BK_MUL);
	assign stp       = mqdv_pkg::step_lut(prev_q[id], cmd.phase_state);

	// product of the latched magnitude, taken by the divider as it starts
	assign prod = 52'(dc_mag_s1) * 52'(mqdv_pkg::MICROS_PER_SECOND);

	mqdv_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(prod), .divisor(elapsed_q),
		.done(div_done), .quotient(quo)
	);

	// saturate the magnitude, then apply the sign
	always_comb begin
		if (neg_s1) begin
			sat_v = (quo > 52'h80000000) ? 32'h80000000 : (32'd0 - quo[31:0]);
		end else begin
			sat_v = (quo > 52'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			mqdv_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.action == mqdv_pkg::ACT_TICK) state_d = mqdv_pkg::BK_SCAN;
				end
			end
			mqdv_pkg::BK_SCAN: begin
				if (elapsed_k >= win) state_d = mqdv_pkg::BK_MUL;
				else if (32'(k_q) == ENCODER_COUNT - 1) state_d = mqdv_pkg::BK_IDLE;
			end
			mqdv_pkg::BK_MUL:   state_d = mqdv_pkg::BK_DIV;
			mqdv_pkg::BK_DIV:   if (div_done) state_d = mqdv_pkg::BK_WRITE;
			mqdv_pkg::BK_WRITE: begin
				if (32'(k_q) == ENCODER_COUNT - 1) state_d = mqdv_pkg::BK_IDLE;
				else state_d = mqdv_pkg::BK_SCAN;
			end
			default: state_d = mqdv_pkg::BK_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mqdv_pkg::BK_IDLE;
			window_q <= mqdv_pkg::WINDOW_RESET;
			k_q      <= '0;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) window_q <= cfg_wdata;
			done <= cmd_pop && cmd.action == mqdv_pkg::ACT_READ;
			if (state_q == mqdv_pkg::BK_IDLE) k_q <= '0;
			else if ((state_q == mqdv_pkg::BK_SCAN && elapsed_k < win) ||
				state_q == mqdv_pkg::BK_WRITE) k_q <= k_q + 1'b1;
		end
	end

	// velocity datapath: magnitude of count delta, elapsed latch, command time, read result
	always_ff @(posedge clk) begin
		if (cmd_pop) now_q <= cmd.time_us;
		if (state_q == mqdv_pkg::BK_SCAN) begin
			neg_s1    <= dc_k[31];
			dc_mag_s1 <= dc_k[31] ? (32'd0 - dc_k) : dc_k;
			elapsed_q <= elapsed_k;
		end
		if (cmd_pop && cmd.action == mqdv_pkg::ACT_READ) begin
			result.position <= cmd.id_ok ? pos_q[id] : 32'd0;
			result.speed    <= cmd.id_ok ? vel_q[id] : 32'd0;
		end
	end

	// per-encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENCODER_COUNT; i++) begin
				pos_q[i] <= '0; prev_q[i] <= '0; vel_q[i] <= '0;
				cw_q[i] <= '0; tw_q[i] <= '0;
			end
		end else begin
			if (cmd_pop && cmd.id_ok) begin
				case (cmd.action)
					mqdv_pkg::ACT_SAMPLE: begin
						pos_q[id]  <= pos_q[id] + {{30{stp[1]}}, stp};
						prev_q[id] <= cmd.phase_state;
					end
					mqdv_pkg::ACT_RESET: begin
						pos_q[id] <= '0;
						cw_q[id]  <= '0;
					end
					mqdv_pkg::ACT_PRELOAD: prev_q[id] <= cmd.phase_state;
					default: ;
				endcase
			end
			if (state_q == mqdv_pkg::BK_WRITE) begin
				vel_q[k_q] <= sat_v;
				cw_q[k_q]  <= pos_q[k_q];
				tw_q[k_q]  <= now_q;
			end
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == mqdv_pkg::BK_IDLE) else $error("pop while busy");
	a_done_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.action) == mqdv_pkg::ACT_READ) else $error("spurious result");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |=> state_q == mqdv_pkg::BK_DIV) else $error("divider start slip");

endmodule
